FILE: rtl/core/signed_integer_to_decimal_ascii_defines.svh
// Assertion macros for the checker file of the decimal text converter.
// No dependencies; take in by `include in files that assert.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define SIDA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sida: same-cycle implication violated");

// Next-cycle implication, quiet during reset.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sida: next-cycle implication violated");

`endif

FILE: rtl/core/sida_pkg.sv
// Shared types and constants of the decimal text converter.
// No dependencies.
package sida_pkg;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_LF    = 8'h0A;

  // Double-dabble correction: a BCD digit of five or more gets three added.
  localparam logic [3:0] DABBLE_MIN = 4'd5;
  localparam logic [3:0] DABBLE_ADD = 4'd3;

  typedef enum logic [1:0] {
    CH_MINUS = 2'd0,
    CH_DIGIT = 2'd1,
    CH_LF    = 2'd2
  } char_kind_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       shift;
    logic       emit;
    char_kind_t sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic cnt_one;
    logic neg;
    logic nl;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/signed_integer_to_decimal_ascii.sv
// Channel  Dir  Beat contents (low bit up)
// s_*      in   tdata: value (64, signed); tuser: add_newline; accepted on tvalid & tready
// m_*      out  tdata: ascii_char (8); tlast: last_char
//
// One value at a time. From the accepting edge the block runs the double-dabble
// shifter (four bits per cycle), then drops leading zero digits, keeping at least
// one, then emits the optional minus, the digits and the optional line feed, one
// byte per beat. Output stalls hold the controller.
// s_tready rises while the final byte still waits in the output register.
// Reset is synchronous, active high, and clears the controller and output valid.
// Depends on sida_pkg, sida_ctrl, sida_datapath.
module signed_integer_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic        s_tuser,   // [0] add_newline
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] ascii_char
  output logic        m_tlast
);
  import sida_pkg::*;

  cmd_t    cmd;
  status_t status;

  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sida_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_value   (s_tdata),
    .in_newline (s_tuser),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: rtl/core/sida_datapath.sv
// Datapath: magnitude, double-dabble BCD shifter, digit counter, output register.
// Depends on sida_pkg.
module sida_datapath #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [63:0]     in_value,
  input  logic            in_newline,
  input  sida_pkg::cmd_t  cmd,
  output sida_pkg::status_t status,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import sida_pkg::*;

  localparam int STEP_BITS = 4;
  localparam int SHIFT_W   = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int STEPS     = SHIFT_W / STEP_BITS;
  localparam int STEP_CW   = $clog2(STEPS);
  localparam int NDIG      = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W     = NDIG * 4;
  localparam int CNT_W     = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] value_bits;
  logic                   sign;
  logic [VALUE_WIDTH-1:0] magnitude;

  logic [SHIFT_W-1:0]     mag;
  logic [BCD_W-1:0]       bcd;
  logic                   neg;
  logic                   nl;
  logic [STEP_CW-1:0]     step_cnt;
  logic [CNT_W-1:0]       dcnt;

  logic [SHIFT_W-1:0]     mag_next;
  logic [BCD_W-1:0]       bcd_next;
  logic [3:0]             top_digit;
  logic [7:0]             char_next;

  assign value_bits = in_value[VALUE_WIDTH-1:0];
  assign sign       = value_bits[VALUE_WIDTH-1];
  assign magnitude  = sign ? (~value_bits + 1'b1) : value_bits;

  // Four double-dabble bit steps per cycle.
  always_comb begin
    bcd_next = bcd;
    mag_next = mag;
    for (int b = 0; b < STEP_BITS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_next[d*4 +: 4] >= DABBLE_MIN) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + DABBLE_ADD;
        end
      end
      {bcd_next, mag_next} = {bcd_next[BCD_W-2:0], mag_next, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= SHIFT_W'(magnitude);
      bcd      <= '0;
      neg      <= sign;
      nl       <= in_newline;
      step_cnt <= STEP_CW'(STEPS - 1);
      dcnt     <= CNT_W'(NDIG);
    end else if (cmd.step) begin
      mag      <= mag_next;
      bcd      <= bcd_next;
      step_cnt <= step_cnt - 1'b1;
    end else if (cmd.shift) begin
      bcd      <= {bcd[BCD_W-5:0], 4'b0000};
      dcnt     <= dcnt - 1'b1;
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

  always_comb begin
    unique case (cmd.sel)
      CH_MINUS: char_next = CHR_MINUS;
      CH_DIGIT: char_next = CHR_ZERO + {4'b0000, top_digit};
      CH_LF:    char_next = CHR_LF;
      default:  char_next = CHR_LF;
    endcase
  end

  // Output register: hold a beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= char_next;
      m_tlast <= cmd.last;
    end
  end

  assign status.conv_done = (step_cnt == '0);
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.cnt_one   = (dcnt == CNT_W'(1));
  assign status.neg       = neg;
  assign status.nl        = nl;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

FILE: rtl/core/sida_ctrl.sv
// Controller: sequences load, BCD conversion, leading-zero skip and byte emission.
// Depends on sida_pkg.
module sida_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sida_pkg::status_t status,
  output sida_pkg::cmd_t    cmd
);
  import sida_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_SKIP  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_DIGIT = 6'b010000,
    S_NL    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = CH_DIGIT;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (status.conv_done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zeros, keep at least one digit.
        if (status.top_zero && !status.cnt_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = status.neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_MINUS;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          cmd.sel   = CH_DIGIT;
          cmd.last  = status.cnt_one && !status.nl;
          if (status.cnt_one) begin
            state_next = status.nl ? S_NL : S_IDLE;
          end
        end
      end
      S_NL: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_LF;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/sida_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
// Depends on sida_pkg and signed_integer_to_decimal_ascii_defines.svh.
`include "signed_integer_to_decimal_ascii_defines.svh"

module sida_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);
  import sida_pkg::*;

  // A stalled beat holds.
  `SIDA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // A value in progress blocks the input until its last byte is produced.
  `SIDA_ASSERT_IMPLY(a_busy_mid_text, clk, rst, m_tvalid && !m_tlast, !s_tready)

  // After a value is accepted, the input is not ready in the next cycle.
  `SIDA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // A line feed always closes the text.
  `SIDA_ASSERT_IMPLY(a_lf_is_last, clk, rst, m_tvalid && (m_tdata == CHR_LF), m_tlast)

endmodule

bind signed_integer_to_decimal_ascii sida_checker u_sida_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for signed_integer_to_decimal_ascii: drives signed values with a newline flag
// and checks every output byte against a local decimal text predictor. Depends on the RTL.
module tb;

  localparam int VW = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 48;
  localparam int RANDOM_ITEMS = 300;
  localparam int UNTHROTTLED_ITEMS = 60;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [63:0] value
  logic        s_tuser;   // [0] add_newline
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] ascii_char
  logic        m_tlast;

  text_beat_t  pending_chars[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;

  signed_integer_to_decimal_ascii #(.VALUE_WIDTH(VW)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected text of one value: optional minus, digits most significant first, optional LF.
  function automatic void predict_decimal_text(input logic [63:0] value, input logic nl);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [3:0]  digits[20];
    logic        negative;
    int          nd;
    text_beat_t  b;
    mask = {64{1'b1}} >> (64 - VW);
    v = value & mask;
    negative = v[VW-1];
    mag = negative ? ((~v + 64'd1) & mask) : v;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % 64'd10);
      nd++;
      mag = mag / 64'd10;
    end while (mag != 0 && nd < 20);
    b.last = 1'b0;
    if (negative) begin
      b.ch = sida_pkg::CHR_MINUS;
      pending_chars.push_back(b);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      b.ch = sida_pkg::CHR_ZERO + 8'(digits[i]);
      pending_chars.push_back(b);
    end
    if (nl) begin
      b.ch = sida_pkg::CHR_LF;
      pending_chars.push_back(b);
    end
    pending_chars[pending_chars.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got_ch,
                                 input logic got_last, input logic [7:0] exp_ch,
                                 input logic exp_last);
    $display("MISMATCH %0s: got char 0x%02h last %0b, expected char 0x%02h last %0b",
             what, got_ch, got_last, exp_ch, exp_last);
    mismatch_count++;
  endtask

  // Send one value; valid stays high across back-to-back beats.
  task automatic send_value(input logic [63:0] value, input logic nl);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= nl;
    do @(posedge clk); while (!s_tready);
    predict_decimal_text(value, nl);
  endtask

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    int          d;
    case ($urandom_range(0, 3))
      0: v = {$urandom(), $urandom()};
      1: begin
        d = $urandom_range(1, 19);
        p = pow10(d - 1);
        v = p + ({$urandom(), $urandom()} % (p * 64'd9));
        if (d == 1) v = 64'($urandom_range(0, 9));
      end
      2: v = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
      default: v = 64'($urandom_range(0, 20));
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
    return v;
  endfunction

  // Output side: random ready stalls while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    text_beat_t exp_b;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata, m_tlast, 8'h00, 1'b0);
      end else begin
        exp_b = pending_chars.pop_front();
        if (m_tdata !== exp_b.ch)
          report_mismatch("ascii_char", m_tdata, m_tlast, exp_b.ch, exp_b.last);
        if (m_tlast !== exp_b.last)
          report_mismatch("last_char", m_tdata, m_tlast, exp_b.ch, exp_b.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_zero_and_units();
    send_value(64'd0, 1'b0);
    send_value(64'd0, 1'b1);
    send_value(64'd1, 1'b0);
    send_value(-64'sd1, 1'b1);
    send_value(64'd9, 1'b1);
    send_value(-64'sd9, 1'b0);
  endtask

  task automatic test_digit_boundaries();
    send_value(64'd10, 1'b0);
    send_value(-64'sd10, 1'b1);
    send_value(64'd99, 1'b1);
    send_value(64'd100, 1'b0);
    send_value(pow10(18), 1'b0);
    send_value(pow10(18) - 64'd1, 1'b1);
    send_value(~pow10(18) + 64'd1, 1'b0);
  endtask

  task automatic test_extremes();
    // most positive and most negative, with and without line feed
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_value(64'h8000_0000_0000_0000, 1'b0);
    send_value(64'h8000_0000_0000_0000, 1'b1);
    send_value(64'h8000_0000_0000_0001, 1'b1);
  endtask

  task automatic test_random_values(input int count);
    for (int i = 0; i < count; i++) send_value(random_value(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_unthrottled();
    idle_en = 1'b0;
    test_random_values(UNTHROTTLED_ITEMS);
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_and_units();
    test_digit_boundaries();
    test_extremes();
    test_random_values(RANDOM_ITEMS);
    test_unthrottled();
    s_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sida_pkg.sv
rtl/core/sida_datapath.sv
rtl/core/sida_ctrl.sv
rtl/core/signed_integer_to_decimal_ascii.sv
rtl/core/sida_checker.sv
tb/sv/tb.sv
